// File: src/qgdp_pkg.sv
// Shared types, widths and helpers for the int4 group dot-product core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qgdp_pkg;

  localparam int NIBBLES    = 8;   // weights packed per word
  localparam int NIBBLE_W   = 4;
  localparam int ACT_W      = 16;  // Q3.12 activation, scale, bias
  localparam int DEQ_W      = 20;  // q*scale+bias, Q.12
  localparam int PROD_W     = 36;  // act * dequantized weight, Q.24
  localparam int PAIR_W     = PROD_W + 1;
  localparam int WSUM_W     = 40;  // sum of eight products
  localparam int ACC_W      = 56;  // accumulator, Q.24
  localparam int SUM_W      = ACC_W + 1;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic        [31:0]      weight_word;
    logic signed [ACT_W-1:0] act_0;
    logic signed [ACT_W-1:0] act_1;
    logic signed [ACT_W-1:0] act_2;
    logic signed [ACT_W-1:0] act_3;
    logic signed [ACT_W-1:0] act_4;
    logic signed [ACT_W-1:0] act_5;
    logic signed [ACT_W-1:0] act_6;
    logic signed [ACT_W-1:0] act_7;
    logic signed [ACT_W-1:0] group_scale;
    logic signed [ACT_W-1:0] group_bias;
    logic                    last_word;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] dot_sum;
    logic                    saturated;
  } out_item_t;

  // One word's reduced contribution, passed from front to back
  typedef struct packed {
    logic signed [WSUM_W-1:0] word_sum;
    logic                     last;
  } word_entry_t;

  // q is unsigned 0..15; result lies in [-2^19, 2^19)
  function automatic logic signed [DEQ_W-1:0] dequant(
    input logic        [NIBBLE_W-1:0] q,
    input logic signed [ACT_W-1:0]    scale,
    input logic signed [ACT_W-1:0]    bias
  );
    logic signed [DEQ_W:0] scaled;
    logic signed [DEQ_W:0] full;
    scaled = $signed({1'b0, q}) * scale;
    full   = scaled + (DEQ_W+1)'(bias);
    return full[DEQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/quantized_int4_group_dot_product_core.sv
// Top level of the int4 group-affine dot-product core.
// Depends on qgdp_pkg, qgdp_front, qgdp_queue, qgdp_back.
//
//   port group  dir   handshake           payload
//   in_*        in    in_valid/in_ready   in_data  (qgdp_pkg::in_item_t)
//   out_*       out   out_valid/out_ready out_data (qgdp_pkg::out_item_t)
//
// Cycles: one item per cycle unless results back up. The front end is a four-stage pipe
//   (dequantize, multiply, pair add, word add); the back end folds one word
//   sum per cycle into the accumulator, so the accumulate loop sets the rate.
// Path: a final item crosses the four front stages, the queue and the result register.
// Reset: rst_n synchronous, active low; clears valids, queue and accumulator.
// Stalls: the result register holds a waiting result while non-final words
//   keep draining; the queue absorbs back-end stalls, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module quantized_int4_group_dot_product_core #(
  parameter int QUEUE_DEPTH = qgdp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire qgdp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output qgdp_pkg::out_item_t      out_data
);
  import qgdp_pkg::*;

  // front -> queue
  logic        push_valid, push_ready;
  word_entry_t push_data;
  // queue -> back
  logic        pop_valid, pop_ready;
  word_entry_t pop_data;

  // eight lanes of dequantize-multiply, reduced to one word sum
  qgdp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples the multiply pipe from the accumulator
  qgdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // saturating Q.24 accumulator and result register
  qgdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // the front end only stalls when its tail cannot enter the queue
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (push_valid && !push_ready))
    else $error("front end stalled with room in the queue");

  // a blocked word sum waits intact at the queue input
  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && !push_ready |=> push_valid && $stable(push_data))
    else $error("word sum changed while waiting for the queue");

  // a new result only comes from popping a final word
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop_valid && pop_ready && pop_data.last))
    else $error("result raised without a final word");

  // a non-final pop never disturbs a waiting result
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("waiting result lost or changed");

endmodule

`default_nettype wire

// File: src/qgdp_front.sv
// Front end: accepts items, dequantizes eight lanes, multiplies, reduces to
// one word sum over four stages. Depends on qgdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qgdp_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire qgdp_pkg::in_item_t     in_data,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output qgdp_pkg::word_entry_t       push_data
);
  import qgdp_pkg::*;

  logic signed [ACT_W-1:0]  acts [NIBBLES];

  logic                     s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic                     s1_last_r, s2_last_r, s3_last_r, s4_last_r;
  logic signed [DEQ_W-1:0]  s1_w_r    [NIBBLES];
  logic signed [ACT_W-1:0]  s1_act_r  [NIBBLES];
  logic signed [PROD_W-1:0] s2_prod_r [NIBBLES];
  logic signed [PAIR_W-1:0] s3_pair_r [NIBBLES/2];
  logic signed [WSUM_W-1:0] s4_sum_r;
  logic                     adv;

  assign acts[0] = in_data.act_0;
  assign acts[1] = in_data.act_1;
  assign acts[2] = in_data.act_2;
  assign acts[3] = in_data.act_3;
  assign acts[4] = in_data.act_4;
  assign acts[5] = in_data.act_5;
  assign acts[6] = in_data.act_6;
  assign acts[7] = in_data.act_7;

  // whole pipe moves together; it holds only when the tail cannot drain
  assign adv        = !s4_valid_r || push_ready;
  assign in_ready   = adv;
  assign push_valid = s4_valid_r;
  assign push_data  = '{word_sum: s4_sum_r, last: s4_last_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  for (genvar j = 0; j < NIBBLES; j++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        s1_w_r[j]    <= dequant(in_data.weight_word[NIBBLE_W*j +: NIBBLE_W],
                                in_data.group_scale, in_data.group_bias);
        s1_act_r[j]  <= acts[j];
        s2_prod_r[j] <= s1_act_r[j] * s1_w_r[j];
      end
    end
  end

  for (genvar p = 0; p < NIBBLES/2; p++) begin : g_pair
    always_ff @(posedge clk) begin
      if (adv) begin
        s3_pair_r[p] <= PAIR_W'(s2_prod_r[2*p]) + PAIR_W'(s2_prod_r[2*p+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r <= in_data.last_word;
      s2_last_r <= s1_last_r;
      s3_last_r <= s2_last_r;
      s4_last_r <= s3_last_r;
      s4_sum_r  <= WSUM_W'(s3_pair_r[0]) + WSUM_W'(s3_pair_r[1])
                 + WSUM_W'(s3_pair_r[2]) + WSUM_W'(s3_pair_r[3]);
    end
  end

endmodule

`default_nettype wire

// File: src/qgdp_queue.sv
// Short FIFO of word sums between front and back ends.
// Depends on qgdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qgdp_queue #(
  parameter int DEPTH = qgdp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push_valid,
  output logic                        push_ready,
  input  wire qgdp_pkg::word_entry_t  push_data,
  output logic                        pop_valid,
  input  wire logic                   pop_ready,
  output qgdp_pkg::word_entry_t       pop_data
);
  import qgdp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  word_entry_t      slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/qgdp_back.sv
// Back end: saturating accumulate of word sums and the result register.
// Depends on qgdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qgdp_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   pop_valid,
  output logic                        pop_ready,
  input  wire qgdp_pkg::word_entry_t  pop_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output qgdp_pkg::out_item_t         out_data
);
  import qgdp_pkg::*;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    clip_r, clip_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;
  logic signed [SUM_W-1:0] sum;
  logic signed [ACC_W-1:0] acc_upd;
  logic                    clip_upd;
  logic                    do_pop;

  // a non-final word never touches the result register
  assign pop_ready = !pop_data.last || !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sum      = SUM_W'(acc_r) + SUM_W'(pop_data.word_sum);
    acc_upd  = sum[ACC_W-1:0];
    clip_upd = clip_r;
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      acc_upd  = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
      clip_upd = 1'b1;
    end

    acc_nxt       = acc_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (do_pop) begin
      if (pop_data.last) begin
        acc_nxt       = '0;
        clip_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{dot_sum: acc_upd, saturated: clip_upd};
      end else begin
        acc_nxt  = acc_upd;
        clip_nxt = clip_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
